[design/dws_pkg.sv]
package dws_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_DUMP_FWD   = 3'd5,
        FN_DUMP_REV   = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SRCH,
        S_DUMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    // ring position of base + off, off below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + {1'b0, off};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[design/deque_with_search.sv]
// Bounded deque of signed 32-bit values kept in a ring of 32 entries in a
// single-port-write, single-port-read memory. An item is taken only while
// the sequencer is idle; s_tuser carries the operation, s_tdata the value
// or search key. Push writes and goes to S_EMIT, pop reads via S_POP to
// S_EMIT, which waits out any output stall. Search walks the stored entries
// through the memory read port, one per cycle, and stops at the first
// match. A dump gives one transfer per entry, front to back or back to
// front, with m_tlast on the final one, at one entry per cycle while
// m_tready stays high. Pop, search and dump on an empty queue and push on a
// full one give a single status transfer. Operation code 7 is taken and
// dropped with no transfer. The result register lets the next item be
// taken while a finished result still waits.
module deque_with_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data
    output logic [2:0]  m_tuser,   // status, found
    output logic        m_tlast
);

    localparam int IW = dws_pkg::IDX_W;
    localparam int CW = dws_pkg::CNT_W;
    localparam int DW = dws_pkg::DATA_W;

    dws_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   front_reg, front_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic            chk_vld_reg, chk_vld_next;
    logic            rev_reg, rev_next;
    logic [DW-1:0]   key_reg, key_next;

    dws_pkg::status_t res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [DW-1:0]    res_data_reg, res_data_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]   m_tdata_reg, m_tdata_next;
    logic [2:0]      m_tuser_reg, m_tuser_next;
    logic            m_tlast_reg, m_tlast_next;

    dws_pkg::store_wr_t wr;
    dws_pkg::store_rd_t rd;
    logic [DW-1:0]      rd_data;

    logic          slot_free;
    logic          m_load;
    logic [CW-1:0] last_off;
    logic [CW-1:0] nxt_i;
    logic [CW-1:0] nxt_off;

    dws_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign slot_free = !m_tvalid_reg || m_tready;
    assign last_off  = cnt_reg - CW'(1);
    assign nxt_i     = iss_reg + CW'(1);
    assign nxt_off   = rev_reg ? (last_off - nxt_i) : nxt_i;

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        cnt_next        = cnt_reg;
        iss_next        = iss_reg;
        chk_vld_next    = chk_vld_reg;
        rev_next        = rev_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_data_next   = res_data_reg;
        m_load          = 1'b0;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        wr              = '0;
        rd              = '0;
        s_tready        = 1'b0;

        case (state_reg)
            dws_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    res_status_next = dws_pkg::STAT_OK;
                    res_found_next  = 1'b0;
                    res_data_next   = '0;
                    key_next        = s_tdata;
                    iss_next        = '0;
                    chk_vld_next    = 1'b0;
                    case (dws_pkg::func_t'(s_tuser))
                        dws_pkg::FN_PUSH_FRONT, dws_pkg::FN_PUSH_BACK: begin
                            state_next = dws_pkg::S_EMIT;
                            if (cnt_reg == dws_pkg::DEPTH_CNT) begin
                                res_status_next = dws_pkg::STAT_FULL;
                            end else begin
                                wr.en    = 1'b1;
                                wr.data  = s_tdata;
                                cnt_next = cnt_reg + CW'(1);
                                if (dws_pkg::func_t'(s_tuser) == dws_pkg::FN_PUSH_FRONT) begin
                                    front_next = dws_pkg::ring_add(front_reg,
                                                     dws_pkg::DEPTH_CNT - CW'(1));
                                    wr.addr    = front_next;
                                end else begin
                                    wr.addr = dws_pkg::ring_add(front_reg, cnt_reg);
                                end
                            end
                        end
                        dws_pkg::FN_POP_FRONT, dws_pkg::FN_POP_BACK: begin
                            if (cnt_reg == '0) begin
                                res_status_next = dws_pkg::STAT_EMPTY;
                                state_next      = dws_pkg::S_EMIT;
                            end else begin
                                rd.en      = 1'b1;
                                cnt_next   = last_off;
                                state_next = dws_pkg::S_POP;
                                if (dws_pkg::func_t'(s_tuser) == dws_pkg::FN_POP_FRONT) begin
                                    rd.addr    = front_reg;
                                    front_next = dws_pkg::ring_add(front_reg, CW'(1));
                                end else begin
                                    rd.addr = dws_pkg::ring_add(front_reg, last_off);
                                end
                            end
                        end
                        dws_pkg::FN_SEARCH: begin
                            if (cnt_reg == '0) begin
                                res_status_next = dws_pkg::STAT_EMPTY;
                                state_next      = dws_pkg::S_EMIT;
                            end else begin
                                state_next = dws_pkg::S_SRCH;
                            end
                        end
                        dws_pkg::FN_DUMP_FWD, dws_pkg::FN_DUMP_REV: begin
                            if (cnt_reg == '0) begin
                                res_status_next = dws_pkg::STAT_EMPTY;
                                state_next      = dws_pkg::S_EMIT;
                            end else begin
                                rev_next   = (dws_pkg::func_t'(s_tuser) == dws_pkg::FN_DUMP_REV);
                                rd.en      = 1'b1;
                                rd.addr    = dws_pkg::ring_add(front_reg,
                                                 rev_next ? last_off : '0);
                                state_next = dws_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            state_next = dws_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dws_pkg::S_POP: begin
                res_data_next = rd_data;
                state_next    = dws_pkg::S_EMIT;
            end
            dws_pkg::S_SRCH: begin
                if (chk_vld_reg && (rd_data == key_reg)) begin
                    res_found_next = 1'b1;
                    state_next     = dws_pkg::S_EMIT;
                end else if (iss_reg == cnt_reg) begin
                    state_next = dws_pkg::S_EMIT;
                end else begin
                    rd.en        = 1'b1;
                    rd.addr      = dws_pkg::ring_add(front_reg, iss_reg);
                    iss_next     = nxt_i;
                    chk_vld_next = 1'b1;
                end
            end
            dws_pkg::S_DUMP: begin
                if (slot_free) begin
                    m_load       = 1'b1;
                    m_tdata_next = rd_data;
                    m_tuser_next = {1'b0, dws_pkg::STAT_OK};
                    m_tlast_next = (iss_reg == last_off);
                    if (iss_reg == last_off) begin
                        state_next = dws_pkg::S_IDLE;
                    end else begin
                        rd.en    = 1'b1;
                        rd.addr  = dws_pkg::ring_add(front_reg, nxt_off);
                        iss_next = nxt_i;
                    end
                end
            end
            dws_pkg::S_EMIT: begin
                if (slot_free) begin
                    m_load       = 1'b1;
                    m_tdata_next = res_data_reg;
                    m_tuser_next = {res_found_reg, res_status_reg};
                    m_tlast_next = 1'b1;
                    state_next   = dws_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dws_pkg::S_IDLE;
            end
        endcase

        m_tvalid_next = m_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dws_pkg::S_IDLE;
            front_reg    <= '0;
            cnt_reg      <= '0;
            iss_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            rev_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            chk_vld_reg  <= chk_vld_next;
            rev_reg      <= rev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_data_reg   <= res_data_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[design/dws_store.sv]
module dws_store (
    input  logic                           aclk,
    input  dws_pkg::store_wr_t             wr,
    input  dws_pkg::store_rd_t             rd,
    output logic [dws_pkg::DATA_W-1:0]     rd_data
);

    logic [dws_pkg::DATA_W-1:0] mem [dws_pkg::DEPTH];
    logic [dws_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[dv/tb_deque_with_search.sv]
module tb_deque_with_search;

    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        dws_pkg::status_t status;
        logic             found;
        logic [31:0]      data;
        logic             last;
    } deque_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value
    logic [2:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // data
    logic [2:0]  m_tuser;   // status, found
    logic        m_tlast;

    // shadow deque state
    logic [31:0] ring_entry [dws_pkg::DEPTH];
    int          ring_front;
    int          ring_count;

    deque_result_t expected_results[$];

    int sender_idle_pct;
    int sink_idle_pct;
    int sink_hold_len;
    int fail_count;
    int items_sent;
    int results_checked;
    int full_refusals;
    int empty_hits;
    int search_hits;
    int stall_cycles;

    deque_with_search u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #4 aclk = ~aclk;
        end
    end

    task automatic predict_deque(input logic [2:0] fn, input logic [31:0] val);
        deque_result_t res;
        int i;
        int pos;
        res.status = dws_pkg::STAT_OK;
        res.found  = 1'b0;
        res.data   = '0;
        res.last   = 1'b1;
        case (fn)
            dws_pkg::FN_PUSH_FRONT, dws_pkg::FN_PUSH_BACK: begin
                if (ring_count >= dws_pkg::DEPTH) begin
                    res.status = dws_pkg::STAT_FULL;
                    full_refusals++;
                end else if (fn == dws_pkg::FN_PUSH_FRONT) begin
                    ring_front = (ring_front + dws_pkg::DEPTH - 1) % dws_pkg::DEPTH;
                    ring_entry[ring_front] = val;
                    ring_count++;
                end else begin
                    ring_entry[(ring_front + ring_count) % dws_pkg::DEPTH] = val;
                    ring_count++;
                end
                expected_results.push_back(res);
            end
            dws_pkg::FN_POP_FRONT, dws_pkg::FN_POP_BACK: begin
                if (ring_count == 0) begin
                    res.status = dws_pkg::STAT_EMPTY;
                    empty_hits++;
                end else if (fn == dws_pkg::FN_POP_FRONT) begin
                    res.data = ring_entry[ring_front];
                    ring_front = (ring_front + 1) % dws_pkg::DEPTH;
                    ring_count--;
                end else begin
                    res.data = ring_entry[(ring_front + ring_count - 1) % dws_pkg::DEPTH];
                    ring_count--;
                end
                expected_results.push_back(res);
            end
            dws_pkg::FN_SEARCH: begin
                if (ring_count == 0) begin
                    res.status = dws_pkg::STAT_EMPTY;
                    empty_hits++;
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        if (ring_entry[(ring_front + i) % dws_pkg::DEPTH] == val) begin
                            res.found = 1'b1;
                        end
                    end
                    if (res.found) begin
                        search_hits++;
                    end
                end
                expected_results.push_back(res);
            end
            dws_pkg::FN_DUMP_FWD, dws_pkg::FN_DUMP_REV: begin
                if (ring_count == 0) begin
                    res.status = dws_pkg::STAT_EMPTY;
                    empty_hits++;
                    expected_results.push_back(res);
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        pos = (fn == dws_pkg::FN_DUMP_FWD) ? i : (ring_count - 1 - i);
                        res.data = ring_entry[(ring_front + pos) % dws_pkg::DEPTH];
                        res.last = (i == ring_count - 1);
                        expected_results.push_back(res);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input logic [2:0] fn, input logic [31:0] val);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        predict_deque(fn, val);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_key();
        if (ring_count > 0 && $urandom_range(1) == 1) begin
            return ring_entry[(ring_front + $urandom_range(ring_count - 1)) % dws_pkg::DEPTH];
        end
        return pick_value();
    endfunction

    function automatic logic [2:0] pick_func();
        int r;
        int push_pct;
        r = $urandom_range(99);
        push_pct = (ring_count < 8) ? 60 : ((ring_count > 26) ? 25 : 45);
        if (r < push_pct) begin
            return ($urandom_range(1) == 1) ? dws_pkg::FN_PUSH_BACK : dws_pkg::FN_PUSH_FRONT;
        end else if (r < push_pct + 25) begin
            return ($urandom_range(1) == 1) ? dws_pkg::FN_POP_BACK : dws_pkg::FN_POP_FRONT;
        end else if (r < push_pct + 38) begin
            return dws_pkg::FN_SEARCH;
        end else if (r < push_pct + 47) begin
            return ($urandom_range(1) == 1) ? dws_pkg::FN_DUMP_REV : dws_pkg::FN_DUMP_FWD;
        end
        return FN_UNUSED;
    endfunction

    // sink side: random stalls plus an optional long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_len > 0) begin
                hold_left = sink_hold_len;
                sink_hold_len = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        deque_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected transfer: tdata=%h tuser=%b tlast=%b",
                             m_tdata, m_tuser, m_tlast);
                end
            end else begin
                exp_res = expected_results.pop_front();
                if (m_tuser[1:0] !== exp_res.status || m_tuser[2] !== exp_res.found ||
                    m_tdata !== exp_res.data || m_tlast !== exp_res.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: exp status=%0d found=%b data=%h last=%b",
                                 exp_res.status, exp_res.found, exp_res.data, exp_res.last);
                        $display("          got status=%0d found=%b data=%h last=%b",
                                 m_tuser[1:0], m_tuser[2], m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // empty queue cases, extremes, front wrap and ignored code
    task automatic test_directed();
        sender_idle_pct = 0;
        sink_idle_pct = 0;
        send_item(dws_pkg::FN_POP_FRONT, 32'h0);
        send_item(dws_pkg::FN_POP_BACK, 32'h0);
        send_item(dws_pkg::FN_SEARCH, 32'h0);
        send_item(dws_pkg::FN_DUMP_FWD, 32'h0);
        send_item(dws_pkg::FN_DUMP_REV, 32'h0);
        send_item(FN_UNUSED, 32'hffff_ffff);
        send_item(dws_pkg::FN_PUSH_FRONT, 32'h8000_0000);
        send_item(dws_pkg::FN_PUSH_BACK, 32'h7fff_ffff);
        send_item(dws_pkg::FN_PUSH_FRONT, 32'h0);
        send_item(dws_pkg::FN_PUSH_BACK, 32'hffff_ffff);
        send_item(dws_pkg::FN_SEARCH, 32'h7fff_ffff);
        send_item(dws_pkg::FN_SEARCH, 32'h1);
        send_item(dws_pkg::FN_SEARCH, 32'h8000_0000);
        send_item(dws_pkg::FN_DUMP_FWD, 32'h0);
        send_item(dws_pkg::FN_DUMP_REV, 32'h0);
        send_item(dws_pkg::FN_POP_FRONT, 32'h0);
        send_item(dws_pkg::FN_POP_BACK, 32'h0);
        send_item(FN_UNUSED, 32'h5555_aaaa);
        send_item(dws_pkg::FN_DUMP_FWD, 32'h0);
    endtask

    // long sink hold-off as the queue fill starts, then full-queue cases and pops down to half
    task automatic test_fill_under_backpressure();
        sender_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold_len = 300;
        while (ring_count < dws_pkg::DEPTH) begin
            send_item(($urandom_range(1) == 1) ? dws_pkg::FN_PUSH_BACK
                                               : dws_pkg::FN_PUSH_FRONT,
                      pick_value());
        end
        send_item(dws_pkg::FN_PUSH_FRONT, $urandom);
        send_item(dws_pkg::FN_PUSH_BACK, $urandom);
        send_item(dws_pkg::FN_SEARCH,
                  ring_entry[(ring_front + dws_pkg::DEPTH - 1) % dws_pkg::DEPTH]);
        send_item(dws_pkg::FN_SEARCH, pick_value());
        send_item(dws_pkg::FN_DUMP_FWD, 32'h0);
        send_item(dws_pkg::FN_DUMP_REV, 32'h0);
        while (ring_count > dws_pkg::DEPTH / 2) begin
            send_item(($urandom_range(1) == 1) ? dws_pkg::FN_POP_BACK
                                               : dws_pkg::FN_POP_FRONT,
                      32'h0);
        end
    endtask

    task automatic test_random_traffic(input int n_items, input int send_idle,
                                       input int recv_idle);
        int done;
        logic [2:0] fn;
        sender_idle_pct = send_idle;
        sink_idle_pct = recv_idle;
        done = 0;
        while (done < n_items) begin
            fn = pick_func();
            send_item(fn, (fn == dws_pkg::FN_SEARCH) ? pick_key() : pick_value());
            if (fn != FN_UNUSED) begin
                done++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        ring_front = 0;
        ring_count = 0;
        sender_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold_len = 0;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        full_refusals = 0;
        empty_hits = 0;
        search_hits = 0;
        stall_cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_under_backpressure();
        test_random_traffic(22, 10, 66);
        test_random_traffic(22, 66, 10);
        test_random_traffic(22, 0, 0);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items, checked %0d transfers", items_sent, results_checked);
        $display("full refusals %0d, empty-queue replies %0d, search hits %0d",
                 full_refusals, empty_hits, search_hits);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
